// ===== src/rsqe_pkg.sv =====
// rsqe_pkg: shared widths, stage payload types and the estimate tables
// for the reciprocal square root estimate pipeline. No dependencies.
package rsqe_pkg;

	localparam int WordW  = 64;
	localparam int FracW  = 52;
	localparam int ExpW   = 11;
	localparam int LzW    = 6;
	localparam int DistW  = 12;
	localparam int TopW   = 15;
	localparam int IdxW   = 5;
	localparam int BaseW  = 26;
	localparam int SlopeW = 11;
	localparam int LerpW  = 11;
	localparam int ProdW  = SlopeW + LerpW;

	localparam logic [WordW-1:0] DefQnan  = 64'h7FF8_0000_0000_0000;
	localparam logic [WordW-1:0] QuietBit = 64'h0008_0000_0000_0000;
	localparam logic [ExpW-1:0]  ExpMax   = 11'h7FF;
	localparam logic [DistW-1:0] ExpBase  = 12'd3068;

	// stage 1: classified operand, leading-zero count of the fraction
	typedef struct packed {
		logic              special;
		logic [WordW-1:0]  spec_bits;
		logic              denorm;
		logic [LzW-1:0]    lz;
		logic [FracW-1:0]  frac;
		logic [ExpW-1:0]   expo;
	} rsqe_s1_t;

	// stage 2: normalized top fraction bits and 3068 - e
	typedef struct packed {
		logic              special;
		logic [WordW-1:0]  spec_bits;
		logic [DistW-1:0]  edist;
		logic [TopW-1:0]   top;
	} rsqe_s2_t;

	// stage 3: table base, slope product and result exponent
	typedef struct packed {
		logic              special;
		logic [WordW-1:0]  spec_bits;
		logic [ExpW-1:0]   ex;
		logic [BaseW-1:0]  base;
		logic [ProdW-1:0]  prod;
	} rsqe_s3_t;

	function automatic logic [BaseW-1:0] base_lut(input logic [IdxW-1:0] idx);
		logic [BaseW-1:0] v;
		case (idx)
			5'd0:  v = 26'h3ffa000;
			5'd1:  v = 26'h3c29000;
			5'd2:  v = 26'h38aa000;
			5'd3:  v = 26'h3572000;
			5'd4:  v = 26'h3279000;
			5'd5:  v = 26'h2fb7000;
			5'd6:  v = 26'h2d26000;
			5'd7:  v = 26'h2ac0000;
			5'd8:  v = 26'h2881000;
			5'd9:  v = 26'h2665000;
			5'd10: v = 26'h2468000;
			5'd11: v = 26'h2287000;
			5'd12: v = 26'h20c1000;
			5'd13: v = 26'h1f12000;
			5'd14: v = 26'h1d79000;
			5'd15: v = 26'h1bf4000;
			5'd16: v = 26'h1a7e800;
			5'd17: v = 26'h17cb800;
			5'd18: v = 26'h1552800;
			5'd19: v = 26'h130c000;
			5'd20: v = 26'h10f2000;
			5'd21: v = 26'h0eff000;
			5'd22: v = 26'h0d2e000;
			5'd23: v = 26'h0b7c000;
			5'd24: v = 26'h09e5000;
			5'd25: v = 26'h0867000;
			5'd26: v = 26'h06ff000;
			5'd27: v = 26'h05ab800;
			5'd28: v = 26'h046a000;
			5'd29: v = 26'h0339800;
			5'd30: v = 26'h0218800;
			5'd31: v = 26'h0105800;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [SlopeW-1:0] slope_lut(input logic [IdxW-1:0] idx);
		logic [SlopeW-1:0] v;
		case (idx)
			5'd0:  v = 11'h7a4;
			5'd1:  v = 11'h700;
			5'd2:  v = 11'h670;
			5'd3:  v = 11'h5f2;
			5'd4:  v = 11'h584;
			5'd5:  v = 11'h524;
			5'd6:  v = 11'h4cc;
			5'd7:  v = 11'h47e;
			5'd8:  v = 11'h43a;
			5'd9:  v = 11'h3fa;
			5'd10: v = 11'h3c2;
			5'd11: v = 11'h38e;
			5'd12: v = 11'h35e;
			5'd13: v = 11'h332;
			5'd14: v = 11'h30a;
			5'd15: v = 11'h2e6;
			5'd16: v = 11'h568;
			5'd17: v = 11'h4f3;
			5'd18: v = 11'h48d;
			5'd19: v = 11'h435;
			5'd20: v = 11'h3e7;
			5'd21: v = 11'h3a2;
			5'd22: v = 11'h365;
			5'd23: v = 11'h32e;
			5'd24: v = 11'h2fc;
			5'd25: v = 11'h2d0;
			5'd26: v = 11'h2a8;
			5'd27: v = 11'h283;
			5'd28: v = 11'h261;
			5'd29: v = 11'h243;
			5'd30: v = 11'h226;
			5'd31: v = 11'h20b;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/rsqe_if.sv =====
// rsqe_if: valid/ready channel interfaces for the operand and estimate beats.
// Depends on nothing.
interface rsqe_operand_if;
	logic        valid;
	logic        ready;
	logic [63:0] operand_bits;

	modport source (output valid, output operand_bits, input ready);
	modport sink   (input valid, input operand_bits, output ready);
endinterface

interface rsqe_estimate_if;
	logic        valid;
	logic        ready;
	logic [63:0] estimate_bits;

	modport source (output valid, output estimate_bits, input ready);
	modport sink   (input valid, input estimate_bits, output ready);
endinterface

// ===== src/rsqe_classify.sv =====
// rsqe_classify: stage 1, special-case detection and fraction leading-zero count.
// Depends on rsqe_pkg.
module rsqe_classify
	import rsqe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  logic [WordW-1:0] up_bits,
	output logic             up_ready,
	output logic             dn_valid,
	output rsqe_s1_t         dn_data,
	input  logic             dn_ready
);

	logic             valid_s1;
	rsqe_s1_t         data_s1;
	rsqe_s1_t         cls;
	logic             sign;
	logic [ExpW-1:0]  expo;
	logic [FracW-1:0] frac;
	logic             found;

	assign sign = up_bits[WordW-1];
	assign expo = up_bits[WordW-2 -: ExpW];
	assign frac = up_bits[FracW-1:0];

	always_comb begin
		cls           = '0;
		cls.frac      = frac;
		cls.expo      = expo;
		cls.denorm    = (expo == '0);
		found         = 1'b0;
		// priority encode the first set fraction bit from the top
		for (int i = FracW - 1; i >= 0; i--) begin
			if (!found && frac[i]) begin
				cls.lz = LzW'(FracW - 1 - i);
				found  = 1'b1;
			end
		end
		if (expo == '0 && frac == '0) begin
			cls.special   = 1'b1;
			cls.spec_bits = {sign, ExpMax, {FracW{1'b0}}};
		end else if (expo == ExpMax) begin
			cls.special = 1'b1;
			if (frac == '0) begin
				cls.spec_bits = sign ? DefQnan : '0;
			end else begin
				cls.spec_bits = up_bits | QuietBit;
			end
		end else if (sign) begin
			cls.special   = 1'b1;
			cls.spec_bits = DefQnan;
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= cls;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

// ===== src/rsqe_normalize.sv =====
// rsqe_normalize: stage 2, denormal shift and exponent distance 3068 - e.
// Depends on rsqe_pkg.
module rsqe_normalize
	import rsqe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	input  rsqe_s1_t up_data,
	output logic     up_ready,
	output logic     dn_valid,
	output rsqe_s2_t dn_data,
	input  logic     dn_ready
);

	logic             valid_s2;
	rsqe_s2_t         data_s2;
	rsqe_s2_t         nrm;
	logic [LzW-1:0]   sh;
	logic [FracW-1:0] fn;

	// a denormal shifts until the hidden bit lands at bit 52; e ends at -lz
	assign sh = up_data.lz + LzW'(1);

	always_comb begin
		nrm           = '0;
		nrm.special   = up_data.special;
		nrm.spec_bits = up_data.spec_bits;
		if (up_data.denorm) begin
			fn        = up_data.frac << sh;
			nrm.edist = ExpBase + DistW'(up_data.lz);
		end else begin
			fn        = up_data.frac;
			nrm.edist = ExpBase - DistW'(up_data.expo);
		end
		nrm.top = fn[FracW-1 -: TopW];
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= nrm;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

// ===== src/rsqe_lookup.sv =====
// rsqe_lookup: stage 3, table row select, base fetch and slope multiply.
// Depends on rsqe_pkg.
module rsqe_lookup
	import rsqe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	input  rsqe_s2_t up_data,
	output logic     up_ready,
	output logic     dn_valid,
	output rsqe_s3_t dn_data,
	input  logic     dn_ready
);

	logic              valid_s3;
	rsqe_s3_t          data_s3;
	rsqe_s3_t          lk;
	logic [IdxW-1:0]   idx;
	logic [SlopeW-1:0] slope;

	// parity of e equals parity of 3068 - e; even e selects the upper half
	assign idx   = {~up_data.edist[0], up_data.top[TopW-1 -: IdxW-1]};
	assign slope = slope_lut(idx);

	always_comb begin
		lk           = '0;
		lk.special   = up_data.special;
		lk.spec_bits = up_data.spec_bits;
		lk.ex        = up_data.edist[DistW-1:1];
		lk.base      = base_lut(idx);
		lk.prod      = {{LerpW{1'b0}}, slope} * {{SlopeW{1'b0}}, up_data.top[LerpW-1:0]};
	end

	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s3 <= lk;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule

// ===== src/rsqe_assemble.sv =====
// rsqe_assemble: stage 4, base minus product and final word select into
// the output register. Depends on rsqe_pkg.
module rsqe_assemble
	import rsqe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  rsqe_s3_t         up_data,
	output logic             up_ready,
	output logic             dn_valid,
	output logic [WordW-1:0] dn_bits,
	input  logic             dn_ready
);

	logic             valid_s4;
	logic [WordW-1:0] bits_s4;
	logic [BaseW-1:0] f;
	logic [WordW-1:0] word;

	assign f = up_data.base - {{(BaseW-ProdW){1'b0}}, up_data.prod};

	always_comb begin
		if (up_data.special) begin
			word = up_data.spec_bits;
		end else begin
			word = {1'b0, up_data.ex, f, {(FracW-BaseW){1'b0}}};
		end
	end

	assign up_ready = !valid_s4 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (up_ready) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			bits_s4 <= word;
		end
	end

	assign dn_valid = valid_s4;
	assign dn_bits  = bits_s4;

endmodule

// ===== src/rsqrt_estimate_double_top.sv =====
// rsqrt_estimate_double_top: reciprocal square root estimate for binary64.
// Depends on rsqe_pkg, rsqe_if and the four rsqe stage modules.
//
// Usage:
//   operand  - sink channel; one beat carries a binary64 bit pattern.
//   estimate - source channel; one beat carries the estimate bit pattern.
//   Every operand beat yields exactly one estimate beat, in order.
//   Path: an accepted operand passes through four register stages in order
//   (classify/leading-zero count, normalize shift, table lookup and slope
//   multiply, subtract and assemble) before its estimate is valid.
//   Throughput: one beat per cycle while estimate.ready stays high; each stage
//   holds one beat and frees itself as soon as the next stage takes it.
//   Special operands (zero, infinity, NaN, negative) travel down the same
//   four stages with their result chosen in stage 1.
//   Reset: arst_n clears all stage valid bits; data registers are not reset.
//   Stall: when estimate.ready is low the output stage holds its beat, and
//   the stall walks back stage by stage only through occupied stages, so up
//   to four beats sit in flight before operand.ready drops. No beat is lost
//   or repeated.
module rsqrt_estimate_double_top
	import rsqe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	rsqe_operand_if.sink           operand,
	rsqe_estimate_if.source        estimate
);

	logic     v1, v2, v3;
	logic     r1, r2, r3;
	rsqe_s1_t d1;
	rsqe_s2_t d2;
	rsqe_s3_t d3;

	// stage 1: classify and count leading zeros
	rsqe_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (operand.valid),
		.up_bits  (operand.operand_bits),
		.up_ready (operand.ready),
		.dn_valid (v1),
		.dn_data  (d1),
		.dn_ready (r1)
	);

	// stage 2: normalize denormals, form 3068 - e
	rsqe_normalize u_normalize (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v1),
		.up_data  (d1),
		.up_ready (r1),
		.dn_valid (v2),
		.dn_data  (d2),
		.dn_ready (r2)
	);

	// stage 3: fetch table row and multiply the slope
	rsqe_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v2),
		.up_data  (d2),
		.up_ready (r2),
		.dn_valid (v3),
		.dn_data  (d3),
		.dn_ready (r3)
	);

	// stage 4: subtract, select, drive the output register
	rsqe_assemble u_assemble (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v3),
		.up_data  (d3),
		.up_ready (r3),
		.dn_valid (estimate.valid),
		.dn_bits  (estimate.estimate_bits),
		.dn_ready (estimate.ready)
	);

`ifndef ASSERT_OFF
	// a ready sink lets every stage advance, so the input must be open
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		estimate.ready |-> operand.ready)
		else $error("operand not ready while estimate sink is ready");

	// a negative result can only be -inf or a NaN carried through
	a_sign_special: assert property (@(posedge clk) disable iff (!arst_n)
		(estimate.valid && estimate.estimate_bits[63])
		|-> (estimate.estimate_bits[62:52] == ExpMax))
		else $error("negative estimate that is not infinity or NaN");

	// finite nonzero estimates have exponent (3068 - e) / 2 for e in -51..2046
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(estimate.valid && estimate.estimate_bits[62:52] != '0
			&& estimate.estimate_bits[62:52] != ExpMax)
		|-> (estimate.estimate_bits[62:52] >= 11'd511
			&& estimate.estimate_bits[62:52] <= 11'd1559))
		else $error("estimate exponent out of range");
`endif

endmodule

// ===== sim/rsqe_estimate_checker.sv =====
`timescale 1ns / 100ps
// rsqe_estimate_checker: watches the operand and estimate channels, predicts each
// reciprocal square root estimate and compares it with what the block returns.
// Depends on rsqe_pkg and rsqe_if.
module rsqe_estimate_checker
	import rsqe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rsqe_operand_if   operand,
	rsqe_estimate_if  estimate,
	output int        fail_count,
	output int        pending
);

	localparam logic [25:0] BaseTable [0:31] = '{
		26'h3ffa000, 26'h3c29000, 26'h38aa000, 26'h3572000,
		26'h3279000, 26'h2fb7000, 26'h2d26000, 26'h2ac0000,
		26'h2881000, 26'h2665000, 26'h2468000, 26'h2287000,
		26'h20c1000, 26'h1f12000, 26'h1d79000, 26'h1bf4000,
		26'h1a7e800, 26'h17cb800, 26'h1552800, 26'h130c000,
		26'h10f2000, 26'h0eff000, 26'h0d2e000, 26'h0b7c000,
		26'h09e5000, 26'h0867000, 26'h06ff000, 26'h05ab800,
		26'h046a000, 26'h0339800, 26'h0218800, 26'h0105800
	};

	localparam logic [10:0] SlopeTable [0:31] = '{
		11'h7a4, 11'h700, 11'h670, 11'h5f2, 11'h584, 11'h524, 11'h4cc, 11'h47e,
		11'h43a, 11'h3fa, 11'h3c2, 11'h38e, 11'h35e, 11'h332, 11'h30a, 11'h2e6,
		11'h568, 11'h4f3, 11'h48d, 11'h435, 11'h3e7, 11'h3a2, 11'h365, 11'h32e,
		11'h2fc, 11'h2d0, 11'h2a8, 11'h283, 11'h261, 11'h243, 11'h226, 11'h20b
	};

	logic [63:0] expected_estimates [$];

	function automatic logic [63:0] rsqrt_estimate_of(input logic [63:0] x);
		logic [52:0] mant;
		logic        sign;
		int          e;
		int          edist;
		logic [14:0] top;
		logic [4:0]  row;
		logic [31:0] lerp;
		sign = x[63];
		e    = int'(x[62:52]);
		mant = {1'b0, x[51:0]};
		if (e == 0 && mant == '0)
			return {sign, 11'h7FF, 52'b0};
		if (e == 2047) begin
			if (mant == '0)
				return sign ? DefQnan : 64'b0;
			return x | QuietBit;
		end
		if (sign)
			return DefQnan;
		// normalize a denormal until the hidden bit shows up
		if (e == 0) begin
			e = 1;
			while (!mant[52]) begin
				mant = mant << 1;
				e--;
			end
		end
		top   = mant[51:37];
		row   = {~e[0], top[14:11]};
		edist = 3068 - e;
		lerp  = 32'(BaseTable[row]) - 32'(SlopeTable[row]) * 32'(top[10:0]);
		return {1'b0, edist[11:1], lerp[25:0], 26'b0};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			expected_estimates.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (operand.valid && operand.ready)
				expected_estimates.push_back(rsqrt_estimate_of(operand.operand_bits));
			if (estimate.valid && estimate.ready) begin
				if (expected_estimates.size() == 0) begin
					$error("estimate_bits: unexpected beat, actual %h", estimate.estimate_bits);
					fail_count++;
				end else begin
					want = expected_estimates.pop_front();
					if (estimate.estimate_bits !== want) begin
						$error("estimate_bits: expected %h, actual %h",
							want, estimate.estimate_bits);
						fail_count++;
					end
				end
			end
			pending = expected_estimates.size();
		end
	end

endmodule

// ===== sim/tb_rsqrt_estimate_double_top.sv =====
`timescale 1ns / 100ps
// tb_rsqrt_estimate_double_top: drives operand beats into the estimate pipeline and
// toggles the result ready line; checking is done by rsqe_estimate_checker.
// Depends on rsqe_pkg, rsqe_if, rsqrt_estimate_double_top and rsqe_estimate_checker.
module tb_rsqrt_estimate_double_top;
	import rsqe_pkg::*;

	localparam int RandomPerPhase = 510;
	localparam int CycleLimit     = 200000;
	localparam int DrainCycles    = 8;   // settle margin after the 4-stage pipeline drains
	localparam int LongHold       = 60;  // far longer than the 4 beats the pipe can hold

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;

	// 0: sender rarely idles, receiver mostly stalls
	// 1: sender mostly idles, receiver rarely stalls
	// 2: full rate on both sides
	int   stim_phase = 0;
	int   snd_idle_pct;
	int   rcv_idle_pct;
	bit   long_hold_done = 1'b0;
	int   hold_left = 0;

	rsqe_operand_if  operand_ch ();
	rsqe_estimate_if estimate_ch ();

	rsqrt_estimate_double_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operand  (operand_ch),
		.estimate (estimate_ch)
	);

	rsqe_estimate_checker estimate_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.operand    (operand_ch),
		.estimate   (estimate_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always_comb begin
		case (stim_phase)
			0: begin
				snd_idle_pct = 15;
				rcv_idle_pct = 83;
			end
			1: begin
				snd_idle_pct = 83;
				rcv_idle_pct = 15;
			end
			default: begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
		endcase
	end

	// Watchdog: a hung handshake or a missing beat ends the run here.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CycleLimit) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Receiver: stall at random, and once at the start of the full-rate phase hold
	// ready low long enough for the pipe to fill and push back on the operand side.
	initial begin
		estimate_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stim_phase == 2 && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left      = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				estimate_ch.ready <= 1'b0;
			end else
				estimate_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	function automatic logic [51:0] rand_frac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[51:0];
	endfunction

	// Mix of operand shapes: mostly positive normals so every table row and both
	// exponent parities get hit, plus denormals of every shift depth, the special
	// encodings with random sign and payload, and raw 64-bit noise.
	function automatic logic [63:0] random_operand();
		int          pick;
		logic [10:0] ex;
		logic [51:0] fr;
		pick = $urandom_range(99);
		if (pick < 55) begin
			if ($urandom_range(4) == 0)
				ex = $urandom_range(1) ? 11'($urandom_range(1, 4))
					: 11'($urandom_range(2043, 2046));
			else
				ex = 11'($urandom_range(1, 2046));
			return {1'b0, ex, rand_frac()};
		end
		if (pick < 70) begin
			// a denormal whose leading one lands anywhere in the fraction
			fr = rand_frac() >> $urandom_range(51);
			if (fr == '0)
				fr = 52'd1;
			return {1'b0, 11'h000, fr};
		end
		if (pick < 82) begin
			case ($urandom_range(3))
				0: return {1'($urandom), 63'b0};
				1: return {1'($urandom), 11'h7FF, 52'b0};
				2: begin
					fr = rand_frac();
					if (fr == '0)
						fr = 52'd1;
					return {1'($urandom), 11'h7FF, fr};
				end
				default: return {1'b1, 11'($urandom_range(1, 2046)), rand_frac()};
			endcase
		end
		return {$urandom, $urandom};
	endfunction

	// Offer one beat; hold it until the pipe takes it. Enter and leave just after
	// a rising edge.
	task automatic send_operand(input logic [63:0] bits);
		while ($urandom_range(99) < snd_idle_pct) begin
			operand_ch.valid <= 1'b0;
			@(posedge clk);
		end
		operand_ch.valid        <= 1'b1;
		operand_ch.operand_bits <= bits;
		@(posedge clk);
		while (!operand_ch.ready)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] directed_ops [$];
		directed_ops = {
			64'h0000_0000_0000_0000,  // +0
			64'h8000_0000_0000_0000,  // -0
			64'h7FF0_0000_0000_0000,  // +inf
			64'hFFF0_0000_0000_0000,  // -inf
			64'h7FF8_0000_0000_0000,  // quiet NaN
			64'h7FF0_0000_0000_0001,  // signaling NaN, low payload
			64'hFFF7_FFFF_FFFF_FFFF,  // negative signaling NaN, full payload
			64'hFFFF_FFFF_FFFF_FFFF,  // all ones: negative quiet NaN
			64'hBFF0_0000_0000_0000,  // -1.0
			64'h8000_0000_0000_0001,  // negative denormal
			64'h0000_0000_0000_0001,  // smallest denormal, deepest shift
			64'h000F_FFFF_FFFF_FFFF,  // largest denormal
			64'h0008_0000_0000_0000,  // denormal, one shift
			64'h0000_0400_0000_0000,  // denormal, mid shift
			64'h0010_0000_0000_0000,  // smallest normal
			64'h7FEF_FFFF_FFFF_FFFF,  // largest normal
			64'h3FF0_0000_0000_0000,  // 1.0, odd exponent
			64'h4000_0000_0000_0000,  // 2.0, even exponent
			64'h3FFF_FFFF_FFFF_FFFF,  // top fraction bits all set, odd exponent
			64'h400F_FFFF_FFFF_FFFF,  // top fraction bits all set, even exponent
			64'h3FF7_FFE0_0000_0000,  // row 7, interpolation field all ones
			64'h4008_0000_0000_0000,  // row 24
			64'h7FE0_0000_0000_0000,  // top even exponent
			64'h0020_0000_0000_0000   // bottom even exponent
		};

		arst_n                  <= 1'b0;
		operand_ch.valid        <= 1'b0;
		operand_ch.operand_bits <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_ops[i])
			send_operand(directed_ops[i]);

		for (int ph = 0; ph < 3; ph++) begin
			stim_phase = ph;
			for (int n = 0; n < RandomPerPhase; n++)
				send_operand(random_operand());
		end
		operand_ch.valid <= 1'b0;

		// Drain: let every expected estimate come back, then settle.
		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
